@@ rtl/assert_macros.svh @@
// Assertion macros used by the top level of the modular domain reduction block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/mdr_pkg.sv @@
// Shared types, constants and register codes of the modular domain reduction block.
package mdr_pkg;

    localparam int RE_BINS_MAX_DEF = 16;
    localparam int IM_BINS_MAX_DEF = 256;
    localparam int MAX_STEPS_DEF   = 64;
    localparam int COUNT_WIDTH_DEF = 32;

    // Restoring divider: 32 numerator bits followed by 48 fraction bits.
    localparam int DIV_FRAC_BITS = 48;
    localparam int DIV_NUM_BITS  = 32;
    localparam int DIV_STEPS     = DIV_FRAC_BITS + DIV_NUM_BITS;

    localparam int HIST_ADDR_W = 16;
    localparam int COUNT_MAX_W = 64;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_RE_OFFSET    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RE_SCALE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RE_BINS_USED = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IM_OFFSET    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IM_SCALE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IM_BINS_USED = 3'd5;

    localparam logic [31:0] RE_OFFSET_RST    = 32'hFF80_0000;
    localparam logic [30:0] RE_SCALE_RST     = 31'd167772160;
    localparam logic [4:0]  RE_BINS_USED_RST = 5'd10;
    localparam logic [31:0] IM_OFFSET_RST    = 32'd14260634;
    localparam logic [30:0] IM_SCALE_RST     = 31'd335544320;
    localparam logic [8:0]  IM_BINS_USED_RST = 9'd183;

    localparam logic [30:0] IM_SAT = 31'h7FFF_FFFF;

    localparam logic OP_MEASURE = 1'b0;
    localparam logic OP_READ    = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [31:0] tau_re;
        logic [31:0] tau_im;
        logic [3:0]  read_re_bin;
        logic [7:0]  read_im_bin;
    } t_req;

    typedef struct packed {
        logic [31:0] reduced_re;
        logic [31:0] reduced_im;
        logic [3:0]  hit_re_bin;
        logic [7:0]  hit_im_bin;
        logic        in_range;
        logic        reduce_failed;
        logic [31:0] bin_count;
        logic [31:0] total_measured;
    } t_rsp;

    typedef struct packed {
        logic                   valid;
        logic                   measure;
        logic                   hit;
        logic [HIST_ADDR_W-1:0] addr;
    } t_hist_cmd;

    typedef struct packed {
        logic                   busy;
        logic                   done;
        logic [COUNT_MAX_W-1:0] count;
        logic [COUNT_MAX_W-1:0] total;
    } t_hist_stat;

    typedef struct packed {
        logic        done;
        logic [63:0] quot;
    } t_div_stat;

endpackage

@@ rtl/mdr_stream_if.sv @@
// Valid/ready stream interface carrying one payload beat.
interface mdr_stream_if #(
    parameter type t_data = logic
);
    logic  valid;
    logic  ready;
    t_data data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/mdr_div.sv @@
// Restoring divider: low 64 bits of floor(num * 2^48 / den), one quotient bit per cycle.
module mdr_div
    import mdr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [47:0] i_den,
    output t_div_stat   o_stat
);
    localparam int CNT_W = $clog2(DIV_STEPS);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [31:0]      r_num;
    logic [47:0]      r_den;
    logic [47:0]      r_rem;
    logic [63:0]      r_quot;

    logic [48:0] w_trial;
    logic [48:0] w_sub;
    logic        w_ge;

    assign w_trial = {r_rem, r_num[31]};
    assign w_sub   = w_trial - {1'b0, r_den};
    assign w_ge    = w_trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == CNT_W'(DIV_STEPS - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_busy) begin
            r_num  <= {r_num[30:0], 1'b0};
            r_rem  <= w_ge ? w_sub[47:0] : w_trial[47:0];
            r_quot <= {r_quot[62:0], w_ge};
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.quot = r_quot;
endmodule

@@ rtl/mdr_hist.sv @@
// Histogram counter memory with clearing pass and measurement counter.
module mdr_hist
    import mdr_pkg::*;
#(
    parameter int NUM_BINS    = RE_BINS_MAX_DEF * IM_BINS_MAX_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_hist_cmd  i_cmd,
    output t_hist_stat o_stat
);
    localparam int ADDR_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

    logic [COUNT_WIDTH-1:0] mem [NUM_BINS];

    logic                   r_clr;
    logic [ADDR_W-1:0]      r_clr_addr;
    logic                   r_ph;
    logic                   r_done;
    logic                   r_measure;
    logic                   r_hit;
    logic [ADDR_W-1:0]      r_addr;
    logic [COUNT_WIDTH-1:0] r_rd;
    logic [COUNT_WIDTH-1:0] r_count;
    logic [COUNT_WIDTH-1:0] r_mcount;

    logic [COUNT_WIDTH-1:0] w_inc;
    logic                   w_wr;

    assign w_inc = (r_rd == '1) ? r_rd : r_rd + 1'b1;
    assign w_wr  = r_ph && r_measure && r_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
            r_ph       <= 1'b0;
            r_done     <= 1'b0;
            r_mcount   <= '0;
        end else begin
            r_done <= r_ph;
            if (r_clr) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == ADDR_W'(NUM_BINS - 1)) begin
                    r_clr <= 1'b0;
                end
            end
            r_ph <= i_cmd.valid;
            if (r_ph) begin
                if (r_measure && (r_mcount != '1)) begin
                    r_mcount <= r_mcount + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid) begin
            r_measure <= i_cmd.measure;
            r_hit     <= i_cmd.hit;
            r_addr    <= i_cmd.addr[ADDR_W-1:0];
        end
        if (r_ph) begin
            r_count <= (r_measure && r_hit) ? w_inc : r_rd;
        end
    end

    // Single write port: clearing sweep or counter update.
    always_ff @(posedge i_clk) begin
        if (r_clr) begin
            mem[r_clr_addr] <= '0;
        end else if (w_wr) begin
            mem[r_addr] <= w_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd <= mem[i_cmd.addr[ADDR_W-1:0]];
    end

    assign o_stat.busy  = r_clr;
    assign o_stat.done  = r_done;
    assign o_stat.count = COUNT_MAX_W'(r_count);
    assign o_stat.total = COUNT_MAX_W'(r_mcount);
endmodule

@@ rtl/modular_domain_reduce_histogram_core.sv @@
// Top level: modular domain reduction sequencer with 2D histogram binning.
//
//  Channel   Dir  Handshake            Beat content
//  i_req     in   valid/ready          opcode, tau_re, tau_im, read bin indices
//  o_rsp     out  valid/ready          reduced point, hit bins, flags, counts
//  i_cfg_*   in   write enable only    register index and write data
//
// A read beat, or a measure beat with a zero imaginary part, goes from IDLE straight
// to HIST, HWAIT and DONE; DONE raises o_rsp valid and returns to IDLE, where i_req
// is ready again. Each inversion squares both parts on the shared multiplier, then
// runs two passes of the bit-serial divider; at most MAX_STEPS inversions are made,
// and a beat that hits the step limit skips binning. After reset the counter memory
// is swept to zero, one entry a cycle, over all RE_BINS_MAX*IM_BINS_MAX entries
// (4096 by default); i_req is not ready then. One beat is in work at a time; the
// output register holds a finished beat while the next one is taken in, and a
// stalled o_rsp holds the sequencer.
`include "assert_macros.svh"

module modular_domain_reduce_histogram_core
    import mdr_pkg::*;
#(
    parameter int RE_BINS_MAX = RE_BINS_MAX_DEF,
    parameter int IM_BINS_MAX = IM_BINS_MAX_DEF,
    parameter int MAX_STEPS   = MAX_STEPS_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    mdr_stream_if.sink            i_req,
    mdr_stream_if.source          o_rsp
);
    localparam int NUM_BINS = RE_BINS_MAX * IM_BINS_MAX;
    localparam int ADDR_W   = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int STEP_W   = $clog2(MAX_STEPS + 1);

    // Sequencer states
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_SQ_RE   = 4'd1;
    localparam logic [3:0] S_SQ_IM   = 4'd2;
    localparam logic [3:0] S_SUM     = 4'd3;
    localparam logic [3:0] S_CHECK   = 4'd4;
    localparam logic [3:0] S_DIV_RE  = 4'd5;
    localparam logic [3:0] S_DIV_IM  = 4'd6;
    localparam logic [3:0] S_DIFF    = 4'd7;
    localparam logic [3:0] S_MUL_RE  = 4'd8;
    localparam logic [3:0] S_MUL_IM  = 4'd9;
    localparam logic [3:0] S_BIN_CHK = 4'd10;
    localparam logic [3:0] S_HIST    = 4'd11;
    localparam logic [3:0] S_HWAIT   = 4'd12;
    localparam logic [3:0] S_DONE    = 4'd13;

    // Configuration registers
    logic [31:0] r_re_offset;
    logic [30:0] r_re_scale;
    logic [4:0]  r_re_bins_used;
    logic [31:0] r_im_offset;
    logic [30:0] r_im_scale;
    logic [8:0]  r_im_bins_used;

    // Sequencer and working registers
    logic [3:0]        r_state;
    logic [23:0]       r_re;      // two's complement Q0.24, always in [-0.5, 0.5)
    logic [30:0]       r_im;      // non-negative Q7.24
    logic [STEP_W-1:0] r_steps;
    logic              r_failed;
    logic              r_is_read;
    logic [63:0]       r_acc;
    logic [63:0]       r_prod;
    logic [23:0]       r_qre;
    logic [31:0]       r_dre;
    logic [31:0]       r_dim;
    logic              r_neg_re;
    logic              r_neg_im;
    logic [14:0]       r_br;
    logic [14:0]       r_bi;
    logic              r_hit;
    logic [ADDR_W-1:0] r_addr;
    logic [3:0]        r_rb;
    logic [7:0]        r_ib;
    t_rsp              r_res;
    logic              r_ovalid;
    t_rsp              r_odata;

    logic        w_accept;
    t_req        w_req;
    logic [30:0] w_im_fold;
    logic [23:0] w_mre;
    logic [31:0] w_ma;
    logic [31:0] w_mb;
    logic [63:0] w_prod;
    logic [33:0] w_diff_re;
    logic [33:0] w_diff_im;
    logic [31:0] w_lr;
    logic [31:0] w_li;
    logic [14:0] w_bi;
    logic        w_bin_hit;
    logic        w_rd_ok;
    logic        w_div_start;
    logic [31:0] w_div_num;
    logic        w_out_free;
    t_div_stat   w_div;
    t_hist_cmd   w_cmd;
    t_hist_stat  w_stat;

    assign w_req      = i_req.data;
    assign w_accept   = i_req.valid && i_req.ready;
    assign w_out_free = !r_ovalid || o_rsp.ready;

    // Fold imaginary part to non-negative; the most negative code saturates.
    always_comb begin
        if (!w_req.tau_im[31]) begin
            w_im_fold = w_req.tau_im[30:0];
        end else if (w_req.tau_im == 32'h8000_0000) begin
            w_im_fold = IM_SAT;
        end else begin
            w_im_fold = 31'(32'd0 - w_req.tau_im);
        end
    end

    assign w_mre = r_re[23] ? (24'd0 - r_re) : r_re;

    // Distance above the bin edges; bit 33 set means below the offset.
    assign w_diff_re = {{10{r_re[23]}}, r_re} - {{2{r_re_offset[31]}}, r_re_offset};
    assign w_diff_im = {3'b000, r_im} - {{2{r_im_offset[31]}}, r_im_offset};

    assign w_lr = (32'(r_re_bins_used) < 32'(RE_BINS_MAX)) ? 32'(r_re_bins_used)
                                                          : 32'(RE_BINS_MAX);
    assign w_li = (32'(r_im_bins_used) < 32'(IM_BINS_MAX)) ? 32'(r_im_bins_used)
                                                          : 32'(IM_BINS_MAX);
    assign w_bi = r_prod[62:48];
    assign w_bin_hit = !r_neg_re && !r_neg_im && (32'(r_br) < w_lr) && (32'(w_bi) < w_li);

    assign w_rd_ok = (32'(w_req.read_re_bin) < 32'(RE_BINS_MAX))
                  && (32'(w_req.read_im_bin) < 32'(IM_BINS_MAX));

    // Shared multiplier: operands picked by the sequencer, product registered.
    always_comb begin
        unique case (r_state)
            S_SQ_RE: begin
                w_ma = 32'(w_mre);
                w_mb = 32'(w_mre);
            end
            S_SQ_IM: begin
                w_ma = 32'(r_im);
                w_mb = 32'(r_im);
            end
            S_MUL_RE: begin
                w_ma = r_dre;
                w_mb = 32'(r_re_scale);
            end
            S_MUL_IM: begin
                w_ma = r_dim;
                w_mb = 32'(r_im_scale);
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end
    assign w_prod = w_ma * w_mb;

    // Launch the real-part division from CHECK, the imaginary one when it ends.
    assign w_div_start = ((r_state == S_CHECK) && (r_acc[63:48] == '0)
                          && (r_steps != STEP_W'(MAX_STEPS)))
                      || ((r_state == S_DIV_RE) && w_div.done);
    assign w_div_num   = (r_state == S_CHECK) ? 32'(w_mre) : 32'(r_im);

    mdr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (r_acc[47:0]),
        .o_stat  (w_div)
    );

    assign w_cmd.valid   = (r_state == S_HIST);
    assign w_cmd.measure = !r_is_read;
    assign w_cmd.hit     = r_hit;
    assign w_cmd.addr    = HIST_ADDR_W'(r_addr);

    mdr_hist #(
        .NUM_BINS    (NUM_BINS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat)
    );

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_re_offset    <= RE_OFFSET_RST;
            r_re_scale     <= RE_SCALE_RST;
            r_re_bins_used <= RE_BINS_USED_RST;
            r_im_offset    <= IM_OFFSET_RST;
            r_im_scale     <= IM_SCALE_RST;
            r_im_bins_used <= IM_BINS_USED_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RE_OFFSET:    r_re_offset    <= i_cfg_data;
                CFG_RE_SCALE:     r_re_scale     <= i_cfg_data[30:0];
                CFG_RE_BINS_USED: r_re_bins_used <= i_cfg_data[4:0];
                CFG_IM_OFFSET:    r_im_offset    <= i_cfg_data;
                CFG_IM_SCALE:     r_im_scale     <= i_cfg_data[30:0];
                CFG_IM_BINS_USED: r_im_bins_used <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // Sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            // Load a finished beat when the output register frees up, else drop it once taken.
            if ((r_state == S_DONE) && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (w_req.opcode == OP_READ || w_im_fold == '0) begin
                            r_state <= S_HIST;
                        end else begin
                            r_state <= S_SQ_RE;
                        end
                    end
                end
                S_SQ_RE: r_state <= S_SQ_IM;
                S_SQ_IM: r_state <= S_SUM;
                S_SUM:   r_state <= S_CHECK;
                S_CHECK: begin
                    if (r_acc[63:48] != '0) begin
                        r_state <= S_DIFF;
                    end else if (r_steps == STEP_W'(MAX_STEPS)) begin
                        r_state <= S_HIST;
                    end else begin
                        r_state <= S_DIV_RE;
                    end
                end
                S_DIV_RE: begin
                    if (w_div.done) begin
                        r_state <= S_DIV_IM;
                    end
                end
                S_DIV_IM: begin
                    if (w_div.done) begin
                        r_state <= S_SQ_RE;
                    end
                end
                S_DIFF:    r_state <= S_MUL_RE;
                S_MUL_RE:  r_state <= S_MUL_IM;
                S_MUL_IM:  r_state <= S_BIN_CHK;
                S_BIN_CHK: r_state <= S_HIST;
                S_HIST:    r_state <= S_HWAIT;
                S_HWAIT: begin
                    if (w_stat.done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    // Hold until the output register is free.
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_is_read <= (w_req.opcode == OP_READ);
                    r_re      <= w_req.tau_re[23:0];
                    r_im      <= w_im_fold;
                    r_steps   <= '0;
                    r_failed  <= (w_req.opcode != OP_READ) && (w_im_fold == '0);
                    r_rb      <= w_req.read_re_bin;
                    r_ib      <= w_req.read_im_bin;
                    r_addr    <= ADDR_W'(32'(w_req.read_re_bin) * 32'(IM_BINS_MAX)
                                         + 32'(w_req.read_im_bin));
                    r_hit     <= (w_req.opcode == OP_READ) && w_rd_ok;
                end
            end
            S_SQ_RE: r_prod <= w_prod;
            S_SQ_IM: begin
                r_acc  <= r_prod;
                r_prod <= w_prod;
            end
            S_SUM: r_acc <= r_acc + r_prod;
            S_CHECK: begin
                if (r_acc[63:48] == '0 && r_steps == STEP_W'(MAX_STEPS)) begin
                    r_failed <= 1'b1;
                end
            end
            S_DIV_RE: begin
                if (w_div.done) begin
                    r_qre <= w_div.quot[23:0];
                end
            end
            S_DIV_IM: begin
                if (w_div.done) begin
                    // -1/tau: real part takes the opposite sign, then wraps mod 1.
                    r_re    <= r_re[23] ? r_qre : (24'd0 - r_qre);
                    r_im    <= (w_div.quot[63:31] != '0) ? IM_SAT : w_div.quot[30:0];
                    r_steps <= r_steps + 1'b1;
                end
            end
            S_DIFF: begin
                r_neg_re <= w_diff_re[33];
                r_neg_im <= w_diff_im[33];
                r_dre    <= w_diff_re[31:0];
                r_dim    <= w_diff_im[31:0];
            end
            S_MUL_RE: r_prod <= w_prod;
            S_MUL_IM: begin
                r_br   <= r_prod[62:48];
                r_prod <= w_prod;
            end
            S_BIN_CHK: begin
                r_bi   <= w_bi;
                r_hit  <= w_bin_hit;
                r_addr <= ADDR_W'(32'(r_br) * 32'(IM_BINS_MAX) + 32'(w_bi));
            end
            S_HWAIT: begin
                if (w_stat.done) begin
                    r_res.in_range       <= r_hit;
                    r_res.bin_count      <= r_hit ? w_stat.count[31:0] : 32'd0;
                    r_res.total_measured <= w_stat.total[31:0];
                    if (r_is_read) begin
                        r_res.reduced_re    <= '0;
                        r_res.reduced_im    <= '0;
                        r_res.hit_re_bin    <= r_rb;
                        r_res.hit_im_bin    <= r_ib;
                        r_res.reduce_failed <= 1'b0;
                    end else begin
                        r_res.reduced_re    <= {{8{r_re[23]}}, r_re};
                        r_res.reduced_im    <= {1'b0, r_im};
                        r_res.hit_re_bin    <= r_hit ? r_br[3:0] : 4'd0;
                        r_res.hit_im_bin    <= r_hit ? r_bi[7:0] : 8'd0;
                        r_res.reduce_failed <= r_failed;
                    end
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    r_odata <= r_res;
                end
            end
            default: ;
        endcase
    end

    assign i_req.ready = (r_state == S_IDLE) && !w_stat.busy;
    assign o_rsp.valid = r_ovalid;
    assign o_rsp.data  = r_odata;

    `ASSERT_IMPLY(a_cmd_not_clearing, i_clk, i_rst_n, w_cmd.valid, !w_stat.busy,
                  "histogram command issued during clearing sweep")
    `ASSERT_IMPLY(a_step_bound, i_clk, i_rst_n, r_state == S_DIV_IM,
                  r_steps < STEP_W'(MAX_STEPS), "inversion beyond the step limit")
    `ASSERT_IMPLY(a_fail_not_binned, i_clk, i_rst_n, o_rsp.valid,
                  !(o_rsp.data.in_range && o_rsp.data.reduce_failed),
                  "failed reduction reported as counted")
    `ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, i_req.valid && i_req.ready,
                 r_state != S_IDLE, "accepted beat did not start the sequencer")
endmodule

@@ tb/tb_modular_domain_reduce_histogram_core.sv @@
// Testbench for the modular domain reduction core: random and directed beats checked against a predictor.
module tb_modular_domain_reduce_histogram_core;
    import mdr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RE_BINS   = RE_BINS_MAX_DEF;
    localparam int IM_BINS   = IM_BINS_MAX_DEF;
    localparam int STEP_CAP  = MAX_STEPS_DEF;
    localparam int SETTLE    = 40;
    localparam longint unsigned UNIT_Q48 = 64'd1 << 48;
    localparam longint IM_CEIL = 64'sd2147483647;

    // Scoreboard: mirrors the histogram state and keeps the responses still owed.
    class reduce_scoreboard;
        t_rsp             owed[$];
        int               errors;
        bit [31:0]        counters[RE_BINS*IM_BINS];
        bit [31:0]        measured;
        logic [31:0]      re_off, im_off;
        logic [30:0]      re_scl, im_scl;
        int               re_used, im_used;

        function new();
            errors   = 0;
            measured = 0;
            foreach (counters[k]) counters[k] = 0;
            re_off  = RE_OFFSET_RST;
            re_scl  = RE_SCALE_RST;
            re_used = RE_BINS_USED_RST;
            im_off  = IM_OFFSET_RST;
            im_scl  = IM_SCALE_RST;
            im_used = IM_BINS_USED_RST;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
            case (idx)
                CFG_RE_OFFSET:    re_off  = val;
                CFG_RE_SCALE:     re_scl  = val[30:0];
                CFG_RE_BINS_USED: re_used = val[4:0];
                CFG_IM_OFFSET:    im_off  = val;
                CFG_IM_SCALE:     im_scl  = val[30:0];
                CFG_IM_BINS_USED: im_used = val[8:0];
                default: ;
            endcase
        endfunction

        // Fold a Q8.24 value modulo one into [-0.5, 0.5).
        function longint wrap_half(longint v);
            longint unsigned u;
            u = v + 64'h80_0000;
            return $signed(u & 64'hFF_FFFF) - 64'sd8388608;
        endfunction

        // floor(n * 2^48 / d), low 64 quotient bits.
        function longint unsigned frac_div(longint unsigned n, longint unsigned d);
            bit [127:0] num, quo;
            num = n;
            num = num << 48;
            quo = num / d;
            return quo[63:0];
        endfunction

        function longint bin_index(longint x, logic [31:0] off, logic [30:0] scl);
            longint          diff;
            longint unsigned prod;
            diff = x - longint'($signed(off));
            if (diff < 0) return -1;
            prod = longint'(diff) * longint'({33'd0, scl});
            return longint'(prod >> 48);
        endfunction

        function t_rsp reduce_and_bin(t_req r);
            t_rsp            e;
            longint          re, im, br, bi;
            longint unsigned mre, mag2, q;
            int              steps, idx;
            bit              failed;
            e = '0;
            if (r.opcode == OP_READ) begin
                e.hit_re_bin     = r.read_re_bin;
                e.hit_im_bin     = r.read_im_bin;
                e.in_range       = 1'b1;
                e.bin_count      = counters[r.read_re_bin * IM_BINS + r.read_im_bin];
                e.total_measured = measured;
                return e;
            end
            re = longint'($signed(r.tau_re));
            im = longint'($signed(r.tau_im));
            if (im < 0) im = -im;
            if (im > IM_CEIL) im = IM_CEIL;
            re = wrap_half(re);
            failed = (im == 0);
            steps  = 0;
            while (!failed) begin
                mre  = (re < 0) ? -re : re;
                mag2 = mre * mre + longint'(im) * longint'(im);
                if (mag2 >= UNIT_Q48) break;
                if (steps >= STEP_CAP) begin
                    failed = 1'b1;
                    break;
                end
                q  = frac_div(mre, mag2);
                re = wrap_half((re < 0) ? q : -q);
                q  = frac_div(im, mag2);
                im = (q > IM_CEIL) ? IM_CEIL : longint'(q);
                steps++;
            end
            if (!failed) begin
                br = bin_index(re, re_off, re_scl);
                bi = bin_index(im, im_off, im_scl);
                if (br >= 0 && br < ((re_used > RE_BINS) ? RE_BINS : re_used) &&
                    bi >= 0 && bi < ((im_used > IM_BINS) ? IM_BINS : im_used)) begin
                    idx = br * IM_BINS + bi;
                    if (counters[idx] != '1) counters[idx]++;
                    e.in_range   = 1'b1;
                    e.hit_re_bin = br[3:0];
                    e.hit_im_bin = bi[7:0];
                    e.bin_count  = counters[idx];
                end
            end
            if (measured != '1) measured++;
            e.reduced_re     = re[31:0];
            e.reduced_im     = im[31:0];
            e.reduce_failed  = failed;
            e.total_measured = measured;
            return e;
        endfunction

        function void note_request(t_req r);
            owed.push_back(reduce_and_bin(r));
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch on %s: got %h, expected %h", what, got, want);
            errors++;
        endtask

        task check_response(t_rsp got);
            t_rsp e;
            if (owed.size() == 0) begin
                report("unexpected beat", got.reduced_re, 32'h0);
                return;
            end
            e = owed.pop_front();
            if (got.reduced_re !== e.reduced_re) report("reduced_re", got.reduced_re, e.reduced_re);
            if (got.reduced_im !== e.reduced_im) report("reduced_im", got.reduced_im, e.reduced_im);
            if (got.hit_re_bin !== e.hit_re_bin) report("hit_re_bin", got.hit_re_bin, e.hit_re_bin);
            if (got.hit_im_bin !== e.hit_im_bin) report("hit_im_bin", got.hit_im_bin, e.hit_im_bin);
            if (got.in_range !== e.in_range) report("in_range", got.in_range, e.in_range);
            if (got.reduce_failed !== e.reduce_failed)
                report("reduce_failed", got.reduce_failed, e.reduce_failed);
            if (got.bin_count !== e.bin_count) report("bin_count", got.bin_count, e.bin_count);
            if (got.total_measured !== e.total_measured)
                report("total_measured", got.total_measured, e.total_measured);
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    mdr_stream_if #(.t_data(t_req)) req_if ();
    mdr_stream_if #(.t_data(t_rsp)) rsp_if ();

    modular_domain_reduce_histogram_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_req      (req_if),
        .o_rsp      (rsp_if)
    );

    reduce_scoreboard sb = new();
    int burst_left = 0;
    int beats_out  = 0;

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Hard stop in case the block hangs.
    initial begin
        #1_000_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Check every beat leaving the block.
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            sb.check_response(rsp_if.data);
            beats_out++;
        end
    end

    // Response backpressure: one of four modes picked at random, plus one long hold-off
    // that lets the input side fill up and stall.
    initial begin
        int mode, tick, hold_left;
        bit held;
        mode = 0;
        tick = 0;
        hold_left = 0;
        held = 1'b0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            tick++;
            if (tick % 64 == 0) mode = $urandom_range(0, 3);
            if (!held && beats_out >= 300) begin
                held = 1'b1;
                hold_left = 600;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                case (mode)
                    0: rsp_if.ready <= 1'b1;
                    1: rsp_if.ready <= $urandom_range(0, 1);
                    2: rsp_if.ready <= (tick % 5 == 0);
                    default: rsp_if.ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // Offer one beat; hold it until accepted. Bursts end in a random gap.
    task send_item(t_req r);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 12);
            if (gap > 0) begin
                req_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        req_if.valid <= 1'b1;
        req_if.data  <= r;
        do @(posedge i_clk); while (!req_if.ready);
        sb.note_request(r);
    endtask

    task measure(logic [31:0] re, logic [31:0] im);
        t_req r;
        r = '0;
        r.opcode = OP_MEASURE;
        r.tau_re = re;
        r.tau_im = im;
        r.read_re_bin = $urandom;
        r.read_im_bin = $urandom;
        send_item(r);
    endtask

    task read_bin(logic [3:0] rb, logic [7:0] ib);
        t_req r;
        r.opcode      = OP_READ;
        r.tau_re      = $urandom;
        r.tau_im      = $urandom;
        r.read_re_bin = rb;
        r.read_im_bin = ib;
        send_item(r);
    endtask

    // Drop valid, wait out every owed beat, then let the block settle before
    // touching registers.
    task drain();
        req_if.valid <= 1'b0;
        burst_left = 0;
        while (sb.owed.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Write all six registers back to back while idle.
    task write_regs(logic [31:0] v0, logic [31:0] v1, logic [31:0] v2,
                    logic [31:0] v3, logic [31:0] v4, logic [31:0] v5);
        logic [31:0] vals[6];
        vals = '{v0, v1, v2, v3, v4, v5};
        req_if.valid <= 1'b0;
        burst_left = 0;
        for (int k = 0; k < 6; k++) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= k[CFG_IDX_W-1:0];
            cfg_data <= vals[k];
            @(posedge i_clk);
            sb.set_reg(k[CFG_IDX_W-1:0], vals[k]);
        end
        cfg_we <= 1'b0;
    endtask

    function logic [31:0] signed_mag(int unsigned mag);
        return $urandom_range(0, 1) ? -mag : mag;
    endfunction

    // One random beat: mostly well-formed moduli of several shapes, some reads.
    task random_item();
        int k;
        k = $urandom_range(0, 99);
        if (k < 18) read_bin($urandom, $urandom);
        else if (k < 40) measure($urandom, $urandom);
        else if (k < 70)
            measure(signed_mag($urandom_range(0, 32'h80_0000)),
                    signed_mag($urandom_range(14529495, 3 << 24)));
        else if (k < 94)
            measure($urandom, signed_mag($urandom_range(1 << 19, 1 << 24)));
        else measure($urandom, signed_mag($urandom_range(1, 1 << 12)));
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_idx      <= CFG_RE_OFFSET;
        cfg_data     <= '0;
        req_if.valid <= 1'b0;
        req_if.data  <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed beats under the reset settings.
        read_bin(4'd0, 8'd0);
        measure(32'h0000_0000, 32'h0000_0000);          // zero imaginary part
        measure(32'h7FFF_FFFF, 32'h0000_0000);
        measure(32'h0012_3456, 32'h8000_0000);          // most negative imaginary part
        measure(32'h8000_0000, 32'h7FFF_FFFF);
        measure(32'hFF80_0000, 32'h00DD_B3D7);          // corner of the domain
        measure(32'h007F_FFFF, 32'h00DD_B3D6);
        measure(32'h0040_0000, 32'h0000_0001);          // tiny imaginary part
        measure(32'h0000_0000, 32'hFF00_0000);          // negative unit imaginary
        measure(32'h0000_0000, 32'h0080_0000);          // plain inversion of i/2
        measure(32'h0010_0000, 32'h0100_0000);
        measure(32'h0010_0000, 32'h0100_0000);          // same bin twice
        measure(32'hFF00_0000, 32'h0001_0000);
        measure(32'hFF7F_0000, 32'h0000_1000);          // below the real offset
        measure(32'h0000_0000, 32'h00C0_0000);
        read_bin(4'd1, 8'd3);
        read_bin(4'd15, 8'd255);
        read_bin(4'd6, 8'd3);

        for (int n = 0; n < 250; n++) random_item();
        drain();

        // Full real axis, wide imaginary axis.
        write_regs(32'hFF80_0000, 32'h1000_0000, 32'd16,
                   32'h00D0_0000, 32'h4000_0000, 32'd256);
        for (int n = 0; n < 260; n++) random_item();
        drain();

        // Extremes: offset limits, largest real and zero imaginary scale, bin counts above the maximum.
        write_regs(32'h8000_0000, 32'hFFFF_FFFF, 32'd31,
                   32'h7FFF_FFFF, 32'h0000_0000, 32'd511);
        for (int n = 0; n < 200; n++) random_item();
        drain();

        // Zero scales and zero bin counts.
        write_regs(32'h0000_0000, 32'h0000_0000, 32'd0,
                   32'h8000_0000, 32'h0000_0000, 32'd0);
        for (int n = 0; n < 120; n++) random_item();
        drain();

        // Every point in a single bin: lowest offsets, zero scales, one bin used per axis.
        write_regs(32'h8000_0000, 32'h0000_0000, 32'd1,
                   32'h8000_0000, 32'h0000_0000, 32'd1);
        for (int n = 0; n < 60; n++) random_item();
        drain();

        // Random moderate settings.
        write_regs(signed_mag($urandom_range(0, 32'h100_0000)),
                   $urandom_range(1 << 24, 1 << 29) | ($urandom & 32'h8000_0000),
                   $urandom_range(1, 16) | ($urandom & 32'hFFFF_FFE0),
                   $urandom_range(32'h60_0000, 32'h100_0000),
                   $urandom_range(1 << 24, 1 << 30) | ($urandom & 32'h8000_0000),
                   $urandom_range(1, 256) | ($urandom & 32'hFFFF_FE00));
        for (int n = 0; n < 200; n++) random_item();
        drain();

        // Back to the reset values, written explicitly.
        write_regs(RE_OFFSET_RST, 32'(RE_SCALE_RST), 32'(RE_BINS_USED_RST),
                   IM_OFFSET_RST, 32'(IM_SCALE_RST), 32'(IM_BINS_USED_RST));
        for (int n = 0; n < 200; n++) random_item();
        drain();

        if (sb.errors == 0 && sb.owed.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/mdr_pkg.sv
rtl/mdr_stream_if.sv
rtl/mdr_div.sv
rtl/mdr_hist.sv
rtl/modular_domain_reduce_histogram_core.sv
tb/tb_modular_domain_reduce_histogram_core.sv
